[sv/sstc_pkg.sv]
// shared types and constants for the session state and credit tracker
`default_nettype none

package sstc_pkg;

  localparam int unsigned BufferSlotsDefault = 8;
  localparam int unsigned FuncW = 4;
  localparam int unsigned IdentW = 62;
  localparam int unsigned LimitW = 62;
  localparam int unsigned LenW = 32;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned InDataW = 160;
  localparam int unsigned InUserW = 8;
  localparam int unsigned OutDataW = 8;
  localparam logic [LimitW-1:0] CountMax = {LimitW{1'b1}};

  typedef enum logic [FuncW-1:0] {
    FN_ESTABLISH = 4'd0,
    FN_DRAIN = 4'd1,
    FN_CLOSE = 4'd2,
    FN_OFFER = 4'd3,
    FN_STREAM_LIMIT = 4'd4,
    FN_OPEN_QUERY = 4'd5,
    FN_NOTE_OPENED = 4'd6,
    FN_DATA_LIMIT = 4'd7,
    FN_SEND_QUERY = 4'd8,
    FN_NOTE_SENT = 4'd9
  } func_e;

  typedef enum logic [PhaseW-1:0] {
    PH_UNEST = 2'd0,
    PH_EST = 2'd1,
    PH_DRAIN = 2'd2,
    PH_CLOSED = 2'd3
  } phase_e;

  typedef struct packed {
    logic step;
  } ctl_cmd_t;

endpackage

`default_nettype wire

[sv/sstc_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module sstc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                     wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/sstc_ctrl.sv]
// handshake controller: input acceptance and result register occupancy
`default_nettype none

module sstc_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output sstc_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign out_valid_o = (state_q == ST_FULL);
  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign cmd_o.step  = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (cmd_o.step) state_d = ST_FULL;
      end
      ST_FULL: begin
        if (cmd_o.step) state_d = ST_FULL;
        else if (out_ready_i) state_d = ST_EMPTY;
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/sstc_dpath.sv]
// session phase, stream slots, limits and counters
`default_nettype none

module sstc_dpath #(
  parameter int unsigned BUFFER_SLOTS = sstc_pkg::BufferSlotsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire sstc_pkg::ctl_cmd_t cmd_i,
  input  wire logic [sstc_pkg::FuncW-1:0]  func_i,
  input  wire logic                        bidi_i,
  input  wire logic [sstc_pkg::IdentW-1:0] stream_ident_i,
  input  wire logic [sstc_pkg::LimitW-1:0] new_limit_i,
  input  wire logic [sstc_pkg::LenW-1:0]   length_i,
  output logic                             ok_o,
  output logic [sstc_pkg::PhaseW-1:0]      session_state_o
);

  localparam int unsigned SlotW = (BUFFER_SLOTS > 1) ? $clog2(BUFFER_SLOTS) : 1;
  localparam int unsigned LimitW = sstc_pkg::LimitW;

  sstc_pkg::phase_e phase_q, phase_d;
  logic [BUFFER_SLOTS-1:0] slot_used_q, slot_used_d;
  logic [LimitW-1:0] bidi_limit_q, bidi_limit_d, uni_limit_q, uni_limit_d;
  logic [LimitW-1:0] bidi_opened_q, bidi_opened_d, uni_opened_q, uni_opened_d;
  logic [LimitW-1:0] data_limit_q, data_limit_d, data_sent_q, data_sent_d;
  logic ok_q, ok_d;
  logic [sstc_pkg::PhaseW-1:0] res_phase_q;

  logic [SlotW-1:0] free_idx;
  logic free_found;
  logic slot_we;
  logic [sstc_pkg::IdentW-1:0] slot_rdata;
  logic [LimitW-1:0] sel_limit, sel_opened;
  logic [LimitW:0] sent_sum;

  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = BUFFER_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used_q[i]) begin
        free_idx = SlotW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign sel_limit  = bidi_i ? bidi_limit_q : uni_limit_q;
  assign sel_opened = bidi_i ? bidi_opened_q : uni_opened_q;
  assign sent_sum   = {1'b0, data_sent_q} + (LimitW + 1)'(length_i);

  always_comb begin
    phase_d = phase_q;
    slot_used_d = slot_used_q;
    bidi_limit_d = bidi_limit_q;
    uni_limit_d = uni_limit_q;
    bidi_opened_d = bidi_opened_q;
    uni_opened_d = uni_opened_q;
    data_limit_d = data_limit_q;
    data_sent_d = data_sent_q;
    slot_we = 1'b0;
    ok_d = 1'b0;
    unique case (func_i)
      sstc_pkg::FN_ESTABLISH: begin
        if (phase_q == sstc_pkg::PH_UNEST) begin
          phase_d = sstc_pkg::PH_EST;
          ok_d = 1'b1;
        end
      end
      sstc_pkg::FN_DRAIN: begin
        if (phase_q == sstc_pkg::PH_EST) begin
          phase_d = sstc_pkg::PH_DRAIN;
          ok_d = 1'b1;
        end
      end
      sstc_pkg::FN_CLOSE: begin
        if (phase_q != sstc_pkg::PH_CLOSED) begin
          phase_d = sstc_pkg::PH_CLOSED;
          ok_d = 1'b1;
        end
      end
      sstc_pkg::FN_OFFER: begin
        if (phase_q != sstc_pkg::PH_UNEST) begin
          ok_d = 1'b1;
        end else if (free_found) begin
          slot_used_d[free_idx] = 1'b1;
          slot_we = 1'b1;
          ok_d = 1'b1;
        end
      end
      sstc_pkg::FN_STREAM_LIMIT: begin
        if (new_limit_i >= sel_limit) begin
          ok_d = 1'b1;
          if (bidi_i) bidi_limit_d = new_limit_i;
          else uni_limit_d = new_limit_i;
        end
      end
      sstc_pkg::FN_OPEN_QUERY: begin
        ok_d = (sel_limit == '0) || (sel_opened < sel_limit);
      end
      sstc_pkg::FN_NOTE_OPENED: begin
        ok_d = 1'b1;
        if (bidi_i) begin
          if (bidi_opened_q != sstc_pkg::CountMax) bidi_opened_d = bidi_opened_q + 1'b1;
        end else begin
          if (uni_opened_q != sstc_pkg::CountMax) uni_opened_d = uni_opened_q + 1'b1;
        end
      end
      sstc_pkg::FN_DATA_LIMIT: begin
        if (new_limit_i >= data_limit_q) begin
          data_limit_d = new_limit_i;
          ok_d = 1'b1;
        end
      end
      sstc_pkg::FN_SEND_QUERY: begin
        ok_d = (data_limit_q == '0) || (sent_sum <= {1'b0, data_limit_q});
      end
      sstc_pkg::FN_NOTE_SENT: begin
        ok_d = 1'b1;
        data_sent_d = sent_sum[LimitW] ? sstc_pkg::CountMax : sent_sum[LimitW-1:0];
      end
      default: ok_d = 1'b0;
    endcase
  end

  // buffered stream ids
  sstc_ram #(
    .Width(sstc_pkg::IdentW),
    .Depth(BUFFER_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.step && slot_we),
    .waddr_i(free_idx),
    .wdata_i(stream_ident_i),
    .raddr_i(free_idx),
    .rdata_o(slot_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sstc_pkg::PH_UNEST;
      slot_used_q <= '0;
      bidi_limit_q <= '0;
      uni_limit_q <= '0;
      bidi_opened_q <= '0;
      uni_opened_q <= '0;
      data_limit_q <= '0;
      data_sent_q <= '0;
    end else if (cmd_i.step) begin
      phase_q <= phase_d;
      slot_used_q <= slot_used_d;
      bidi_limit_q <= bidi_limit_d;
      uni_limit_q <= uni_limit_d;
      bidi_opened_q <= bidi_opened_d;
      uni_opened_q <= uni_opened_d;
      data_limit_q <= data_limit_d;
      data_sent_q <= data_sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      ok_q <= ok_d;
      res_phase_q <= phase_d;
    end
  end

  assign ok_o = ok_q;
  assign session_state_o = res_phase_q;

endmodule

`default_nettype wire

[sv/session_state_and_credit_tracker_core.sv]
// top level of the session state and credit tracker
// a result is valid in the cycle after its input transfer
// throughput: one item per cycle while the result side keeps taking transfers
// every event is a compare, an add or a first-free pick over the slot bits
// reset clears phase, slot bits, limits and counters at once; the id ram is not cleared
`default_nettype none

module session_state_and_credit_tracker_core #(
  parameter int unsigned BUFFER_SLOTS = sstc_pkg::BufferSlotsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // stream_ident [61:0], new_limit [123:62], length [155:124], zero fill
  input  wire logic [sstc_pkg::InDataW-1:0] s_axis_tdata,
  // func [3:0], bidi [4], zero fill
  input  wire logic [sstc_pkg::InUserW-1:0] s_axis_tuser,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // ok [0], session_state [2:1], zero fill
  output logic [sstc_pkg::OutDataW-1:0] m_axis_tdata
);

  sstc_pkg::ctl_cmd_t cmd;
  logic ok;
  logic [sstc_pkg::PhaseW-1:0] session_state;

  sstc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  sstc_dpath #(
    .BUFFER_SLOTS(BUFFER_SLOTS)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (s_axis_tuser[3:0]),
    .bidi_i         (s_axis_tuser[4]),
    .stream_ident_i (s_axis_tdata[61:0]),
    .new_limit_i    (s_axis_tdata[123:62]),
    .length_i       (s_axis_tdata[155:124]),
    .ok_o           (ok),
    .session_state_o(session_state)
  );

  assign m_axis_tdata = {5'b0, session_state, ok};

endmodule

`default_nettype wire

[sv/sstc_checker.sv]
// port checker for the session state and credit tracker, with its bind
`default_nettype none

module sstc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [sstc_pkg::OutDataW-1:0] m_axis_tdata
);

  logic in_xfer, out_xfer;
  logic [1:0] pending_q;
  logic [sstc_pkg::PhaseW-1:0] last_phase_q;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      last_phase_q <= sstc_pkg::PH_UNEST;
    end else begin
      if (in_xfer && !out_xfer) pending_q <= pending_q + 2'd1;
      else if (!in_xfer && out_xfer) pending_q <= pending_q - 2'd1;
      if (out_xfer) last_phase_q <= m_axis_tdata[2:1];
    end
  end

  // phase only moves forward
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> m_axis_tdata[2:1] >= last_phase_q)
    else $error("session phase went backwards");

  // no result without an earlier input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pending_q != 2'd0)
    else $error("result without input");

  // at most one result held at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 2'd1)
    else $error("results overrun");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind session_state_and_credit_tracker_core sstc_checker u_sstc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
